/* hw/rtl/incircle_test_2d_unit_assert.svh */
// Assertion macros shared by the incircle unit.
`ifndef INCIRCLE_TEST_2D_UNIT_ASSERT_SVH
`define INCIRCLE_TEST_2D_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define IC2D_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define IC2D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/ic2d_pkg.sv */
`default_nettype none

package ic2d_pkg;

    localparam int TOL_WIDTH = 48;
    localparam int MUL_CHUNK = 32;

    typedef enum logic [1:0] {
        REL_INSIDE  = 2'd0,
        REL_OUTSIDE = 2'd1,
        REL_ON      = 2'd2
    } t_relation;

endpackage

`default_nettype wire

/* hw/rtl/incircle_test_2d_unit.sv */
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+------------------------------------
//  input   | in        | i_valid / o_stall  | i_a_x .. i_q_z, COORD_WIDTH each
//  result  | out       | o_valid / i_stall  | o_relation, 2 bits
//  config  | in        | i_cfg_we           | i_cfg_wdata, 48-bit tolerance
//
//  One word is accepted per cycle while o_stall is low; the word passes eleven
//  pipeline stages and then an output register before o_valid rises.
//  The determinant is built by chunked multipliers, two stages each.
//  Reset is synchronous and active low; it clears valid bits and tolerance.
//  A stalled output fills one skid word, after which o_stall freezes the pipe.
`default_nettype none

`include "incircle_test_2d_unit_assert.svh"

module incircle_test_2d_unit import ic2d_pkg::*; #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [TOL_WIDTH-1:0]          i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_a_x,
    input  logic signed [COORD_WIDTH-1:0] i_a_z,
    input  logic signed [COORD_WIDTH-1:0] i_b_x,
    input  logic signed [COORD_WIDTH-1:0] i_b_z,
    input  logic signed [COORD_WIDTH-1:0] i_c_x,
    input  logic signed [COORD_WIDTH-1:0] i_c_z,
    input  logic signed [COORD_WIDTH-1:0] i_q_x,
    input  logic signed [COORD_WIDTH-1:0] i_q_z,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [1:0]                    o_relation
);

    localparam int W    = COORD_WIDTH;
    localparam int DLW  = W + 1;
    localparam int SQW  = 2 * W + 2;
    localparam int T2W  = 2 * W + 3;
    localparam int MW   = DLW + SQW;
    localparam int EW   = DLW + T2W;
    localparam int TW   = 3 * W + 4;
    localparam int UW   = 3 * W + 5;
    localparam int PW   = DLW + UW;
    localparam int DTW  = 4 * W + 7;
    localparam int CW   = (4 * W + 8 > TOL_WIDTH + 2) ? 4 * W + 8 : TOL_WIDTH + 2;
    localparam int NSTG = 11;

    logic                  en;
    logic                  full;
    logic [NSTG-1:0]       r_v;
    logic [TOL_WIDTH-1:0]  r_tol;

    logic signed [DLW-1:0] r_dx [3];
    logic signed [DLW-1:0] r_dz [3];
    logic signed [DLW-1:0] r_dx2 [3];
    logic signed [DLW-1:0] r_dz2 [3];
    logic signed [SQW-1:0] r_sxx [3];
    logic signed [SQW-1:0] r_szz [3];
    logic signed [SQW-1:0] r_pa;
    logic signed [SQW-1:0] r_pb;
    logic signed [DLW-1:0] r_dx3 [3];
    logic signed [DLW-1:0] r_dz3 [3];
    logic signed [SQW-1:0] r_sq [3];
    logic signed [T2W-1:0] r_t2;
    logic signed [DLW-1:0] r_dx0_q [4];
    logic signed [DLW-1:0] r_dz0_q [4];
    logic signed [MW-1:0]  m0, m1, m2, m3;
    logic signed [EW-1:0]  e0, e1;
    logic signed [TW-1:0]  r_t0, r_t1;
    logic signed [EW-1:0]  r_e0, r_e1;
    logic signed [UW-1:0]  r_u, r_w;
    logic signed [PW-1:0]  p0, p1;
    logic signed [DTW-1:0] r_det;
    logic signed [CW-1:0]  det_x;
    logic signed [CW-1:0]  tol_x;
    logic signed [CW-1:0]  low_sum;
    t_relation             n_rel;
    t_relation             r_rel;
    t_relation             out_rel;

    assign en      = !full;
    assign o_stall = full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NSTG-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx[0] <= DLW'(i_a_x) - DLW'(i_q_x);
            r_dz[0] <= DLW'(i_a_z) - DLW'(i_q_z);
            r_dx[1] <= DLW'(i_b_x) - DLW'(i_q_x);
            r_dz[1] <= DLW'(i_b_z) - DLW'(i_q_z);
            r_dx[2] <= DLW'(i_c_x) - DLW'(i_q_x);
            r_dz[2] <= DLW'(i_c_z) - DLW'(i_q_z);

            for (int i = 0; i < 3; i++) begin
                r_sxx[i] <= SQW'(r_dx[i]) * SQW'(r_dx[i]);
                r_szz[i] <= SQW'(r_dz[i]) * SQW'(r_dz[i]);
                r_dx2[i] <= r_dx[i];
                r_dz2[i] <= r_dz[i];
            end
            r_pa <= SQW'(r_dx[1]) * SQW'(r_dz[2]);
            r_pb <= SQW'(r_dz[1]) * SQW'(r_dx[2]);

            for (int i = 0; i < 3; i++) begin
                r_sq[i]  <= r_sxx[i] + r_szz[i];
                r_dx3[i] <= r_dx2[i];
                r_dz3[i] <= r_dz2[i];
            end
            r_t2 <= T2W'(r_pa) - T2W'(r_pb);

            r_dx0_q[0] <= r_dx3[0];
            r_dz0_q[0] <= r_dz3[0];
            for (int i = 1; i < 4; i++) begin
                r_dx0_q[i] <= r_dx0_q[i-1];
                r_dz0_q[i] <= r_dz0_q[i-1];
            end

            r_t0 <= TW'(m0) - TW'(m1);
            r_t1 <= TW'(m2) - TW'(m3);
            r_e0 <= e0;
            r_e1 <= e1;

            r_u <= UW'(r_t0) + UW'(r_e0);
            r_w <= UW'(r_e1) - UW'(r_t1);

            r_det <= DTW'(p0) + DTW'(p1);

            r_rel <= n_rel;
        end
    end

    // Cofactor products of rows b and c.
    ic2d_mul #(.AW(DLW), .BW(SQW)) u_mul_m0 (
        .i_clk(i_clk), .i_en(en), .i_a(r_dz3[1]), .i_b(r_sq[2]), .o_p(m0)
    );
    ic2d_mul #(.AW(DLW), .BW(SQW)) u_mul_m1 (
        .i_clk(i_clk), .i_en(en), .i_a(r_dz3[2]), .i_b(r_sq[1]), .o_p(m1)
    );
    ic2d_mul #(.AW(DLW), .BW(SQW)) u_mul_m2 (
        .i_clk(i_clk), .i_en(en), .i_a(r_dx3[1]), .i_b(r_sq[2]), .o_p(m2)
    );
    ic2d_mul #(.AW(DLW), .BW(SQW)) u_mul_m3 (
        .i_clk(i_clk), .i_en(en), .i_a(r_dx3[2]), .i_b(r_sq[1]), .o_p(m3)
    );

    // The squared length of row a is folded in as dx0*dx0*t2 + dz0*dz0*t2.
    ic2d_mul #(.AW(DLW), .BW(T2W)) u_mul_e0 (
        .i_clk(i_clk), .i_en(en), .i_a(r_dx3[0]), .i_b(r_t2), .o_p(e0)
    );
    ic2d_mul #(.AW(DLW), .BW(T2W)) u_mul_e1 (
        .i_clk(i_clk), .i_en(en), .i_a(r_dz3[0]), .i_b(r_t2), .o_p(e1)
    );

    ic2d_mul #(.AW(DLW), .BW(UW)) u_mul_p0 (
        .i_clk(i_clk), .i_en(en), .i_a(r_dx0_q[3]), .i_b(r_u), .o_p(p0)
    );
    ic2d_mul #(.AW(DLW), .BW(UW)) u_mul_p1 (
        .i_clk(i_clk), .i_en(en), .i_a(r_dz0_q[3]), .i_b(r_w), .o_p(p1)
    );

    // The negated determinant below minus tolerance means the determinant is above it.
    assign det_x   = CW'(r_det);
    assign tol_x   = $signed({{(CW-TOL_WIDTH){1'b0}}, r_tol});
    assign low_sum = det_x + tol_x;

    always_comb begin
        if (det_x > tol_x) begin
            n_rel = REL_INSIDE;
        end else if (low_sum[CW-1]) begin
            n_rel = REL_OUTSIDE;
        end else begin
            n_rel = REL_ON;
        end
    end

    ic2d_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_v[NSTG-1]),
        .i_relation (r_rel),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_relation (out_rel),
        .o_full     (full)
    );

    assign o_relation = out_rel;

    `IC2D_ASSERT_NOW(a_skid_behind_head, i_clk, i_rst_n, o_stall, o_valid, "skid word without output word")
    `IC2D_ASSERT_NEXT(a_skid_kept, i_clk, i_rst_n, o_stall && i_stall, o_stall, "skid word lost under stall")
    `IC2D_ASSERT_NEXT(a_pipe_frozen, i_clk, i_rst_n, o_stall, $stable(r_v), "pipeline moved while full")

endmodule

`default_nettype wire

/* hw/rtl/ic2d_mul.sv */
`default_nettype none

module ic2d_mul import ic2d_pkg::*; #(
    parameter int AW = 17,
    parameter int BW = 34
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [AW-1:0]    i_a,
    input  logic signed [BW-1:0]    i_b,
    output logic signed [AW+BW-1:0] o_p
);

    localparam int NC  = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int PW  = AW + BW;
    localparam int PPW = AW + MUL_CHUNK + 1;
    localparam int BXW = NC * MUL_CHUNK;

    logic signed [BXW-1:0] bx;
    logic signed [PPW-1:0] n_pp [NC];
    logic signed [PPW-1:0] r_pp [NC];
    logic signed [PW-1:0]  n_p;
    logic signed [PW-1:0]  r_p;

    assign bx = BXW'(i_b);

    // Lower chunks of the wide operand are unsigned, the top chunk carries the sign.
    always_comb begin
        for (int k = 0; k < NC; k++) begin
            if (k == NC - 1) begin
                n_pp[k] = PPW'(i_a) * PPW'($signed({bx[BXW-1], bx[k*MUL_CHUNK +: MUL_CHUNK]}));
            end else begin
                n_pp[k] = PPW'(i_a) * PPW'($signed({1'b0, bx[k*MUL_CHUNK +: MUL_CHUNK]}));
            end
        end
    end

    always_comb begin
        n_p = '0;
        for (int k = 0; k < NC; k++) begin
            n_p = n_p + (PW'(r_pp[k]) <<< (k * MUL_CHUNK));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NC; k++) begin
                r_pp[k] <= n_pp[k];
            end
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

/* hw/rtl/ic2d_out.sv */
`default_nettype none

module ic2d_out import ic2d_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_relation   i_relation,
    input  logic        i_stall,
    output logic        o_valid,
    output t_relation   o_relation,
    output logic        o_full
);

    logic      r_ov;
    logic      r_sv;
    t_relation r_rel;
    t_relation r_srel;
    logic      n_ov;
    logic      n_sv;
    t_relation n_rel;
    t_relation n_srel;
    logic      take;

    assign take = r_ov && !i_stall;

    // The skid word only fills while the pipeline still runs into a stalled output.
    always_comb begin
        n_ov   = r_ov;
        n_sv   = r_sv;
        n_rel  = r_rel;
        n_srel = r_srel;
        if (r_sv) begin
            if (take) begin
                n_ov  = 1'b1;
                n_rel = r_srel;
                n_sv  = 1'b0;
            end
        end else if (!r_ov || take) begin
            n_ov  = i_valid;
            n_rel = i_relation;
        end else if (i_valid) begin
            n_sv   = 1'b1;
            n_srel = i_relation;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            r_ov <= n_ov;
            r_sv <= n_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rel  <= n_rel;
        r_srel <= n_srel;
    end

    assign o_valid    = r_ov;
    assign o_relation = r_rel;
    assign o_full     = r_sv;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import ic2d_pkg::*;

    localparam int COORD_W     = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_WAIT  = 20;

    // Integer points on a circle of radius 5 around the origin.
    localparam int CIRC_X [12] = '{5, 0, -5, 0, 3, 4, -3, -4, 3, 4, -3, -4};
    localparam int CIRC_Z [12] = '{0, 5, 0, -5, 4, 3, 4, 3, -4, -3, -4, -3};

    typedef struct packed {
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_z;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_z;
        logic signed [COORD_W-1:0] c_x;
        logic signed [COORD_W-1:0] c_z;
        logic signed [COORD_W-1:0] q_x;
        logic signed [COORD_W-1:0] q_z;
    } t_triangle_query;

    typedef struct {
        int        seq;
        t_relation rel;
    } t_relation_entry;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [TOL_WIDTH-1:0]      i_cfg_wdata = '0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic signed [COORD_W-1:0] i_a_x = '0;
    logic signed [COORD_W-1:0] i_a_z = '0;
    logic signed [COORD_W-1:0] i_b_x = '0;
    logic signed [COORD_W-1:0] i_b_z = '0;
    logic signed [COORD_W-1:0] i_c_x = '0;
    logic signed [COORD_W-1:0] i_c_z = '0;
    logic signed [COORD_W-1:0] i_q_x = '0;
    logic signed [COORD_W-1:0] i_q_z = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic [1:0]                o_relation;

    t_relation_entry      pending_relations [$];
    t_relation_entry      oldest_relation;
    logic [TOL_WIDTH-1:0] tolerance_model = '0;
    int                   words_sent = 0;
    int                   mismatch_count = 0;
    int                   cycle_count = 0;
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;
    int                   hold_requests = 0;
    int                   hold_served = 0;
    int                   hold_left = 0;

    incircle_test_2d_unit #(
        .COORD_WIDTH(COORD_W)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_a_x      (i_a_x),
        .i_a_z      (i_a_z),
        .i_b_x      (i_b_x),
        .i_b_z      (i_b_z),
        .i_c_x      (i_c_x),
        .i_c_z      (i_c_z),
        .i_q_x      (i_q_x),
        .i_q_z      (i_q_z),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_relation (o_relation)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // A hold request keeps the result side stalled for a long stretch.
    always @(posedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_relations.size() == 0) begin
                report_mismatch("result with no word outstanding");
            end else begin
                oldest_relation = pending_relations.pop_front();
                if (o_relation !== oldest_relation.rel) begin
                    report_mismatch($sformatf("word %0d: relation %0d, expected %0d",
                        oldest_relation.seq, o_relation, oldest_relation.rel));
                end
            end
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    function automatic logic signed [127:0] wide(input logic signed [COORD_W-1:0] v);
        return 128'(v);
    endfunction

    function automatic logic signed [127:0] negated_det(input t_triangle_query w);
        logic signed [127:0] dx [3];
        logic signed [127:0] dz [3];
        logic signed [127:0] sq [3];
        logic signed [127:0] minor_z, minor_x, minor_xz;
        int i;
        dx[0] = wide(w.a_x) - wide(w.q_x);
        dz[0] = wide(w.a_z) - wide(w.q_z);
        dx[1] = wide(w.b_x) - wide(w.q_x);
        dz[1] = wide(w.b_z) - wide(w.q_z);
        dx[2] = wide(w.c_x) - wide(w.q_x);
        dz[2] = wide(w.c_z) - wide(w.q_z);
        for (i = 0; i < 3; i++) begin
            sq[i] = dx[i] * dx[i] + dz[i] * dz[i];
        end
        minor_z  = dz[1] * sq[2] - sq[1] * dz[2];
        minor_x  = dx[1] * sq[2] - sq[1] * dx[2];
        minor_xz = dx[1] * dz[2] - dz[1] * dx[2];
        return -(dx[0] * minor_z - dz[0] * minor_x + sq[0] * minor_xz);
    endfunction

    function automatic t_relation incircle_relation(input t_triangle_query w,
                                                    input logic [TOL_WIDTH-1:0] tol);
        logic signed [127:0] r;
        logic signed [127:0] band;
        r = negated_det(w);
        band = $signed({{(128 - TOL_WIDTH){1'b0}}, tol});
        if (r < -band) begin
            return REL_INSIDE;
        end else if (r > band) begin
            return REL_OUTSIDE;
        end
        return REL_ON;
    endfunction

    function automatic t_triangle_query make_word(input int ax, input int az, input int bx,
                                                  input int bz, input int cx, input int cz,
                                                  input int qx, input int qz);
        t_triangle_query w;
        w.a_x = COORD_W'(ax);
        w.a_z = COORD_W'(az);
        w.b_x = COORD_W'(bx);
        w.b_z = COORD_W'(bz);
        w.c_x = COORD_W'(cx);
        w.c_z = COORD_W'(cz);
        w.q_x = COORD_W'(qx);
        w.q_z = COORD_W'(qz);
        return w;
    endfunction

    // Mix of full-range, small, cocircular, near-cocircular and degenerate words.
    function automatic t_triangle_query random_word();
        int v [8];
        int pick [12];
        int kind, span, cx, cz, k, j, t, ddx, ddz;
        kind = $urandom_range(0, 9);
        for (j = 0; j < 8; j++) begin
            v[j] = int'($urandom_range(0, 65535)) - 32768;
        end
        if (kind == 3 || kind == 4) begin
            span = $urandom_range(1, 64);
            for (j = 0; j < 8; j++) begin
                v[j] = int'($urandom_range(0, 2 * span)) - span;
            end
        end else if (kind == 5 || kind == 6 || kind == 7) begin
            cx = int'($urandom_range(0, 40000)) - 20000;
            cz = int'($urandom_range(0, 40000)) - 20000;
            k = (kind == 7) ? $urandom_range(1, 1000) : $urandom_range(1, 20);
            for (j = 0; j < 12; j++) begin
                pick[j] = j;
            end
            for (j = 0; j < 4; j++) begin
                t = $urandom_range(j, 11);
                ddx = pick[j];
                pick[j] = pick[t];
                pick[t] = ddx;
                v[2 * j] = cx + k * CIRC_X[pick[j]];
                v[2 * j + 1] = cz + k * CIRC_Z[pick[j]];
            end
            if (kind == 7) begin
                v[6] = v[6] + ($urandom_range(0, 1) ? 1 : -1);
            end
        end else if (kind == 8) begin
            v[0] = int'($urandom_range(0, 20000)) - 10000;
            v[1] = int'($urandom_range(0, 20000)) - 10000;
            ddx = int'($urandom_range(0, 10000)) - 5000;
            ddz = int'($urandom_range(0, 10000)) - 5000;
            v[2] = v[0] + ddx;
            v[3] = v[1] + ddz;
            v[4] = v[0] + 2 * ddx;
            v[5] = v[1] + 2 * ddz;
        end else if (kind == 9) begin
            v[2] = v[0];
            v[3] = v[1];
        end
        return make_word(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
    endfunction

    task automatic send_word(input t_triangle_query w);
        int gap;
        gap = 0;
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_a_x <= w.a_x;
        i_a_z <= w.a_z;
        i_b_x <= w.b_x;
        i_b_z <= w.b_z;
        i_c_x <= w.c_x;
        i_c_z <= w.c_z;
        i_q_x <= w.q_x;
        i_q_z <= w.q_z;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        pending_relations.push_back('{seq: words_sent, rel: incircle_relation(w, tolerance_model)});
        words_sent++;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_relations.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_tolerance(input logic [TOL_WIDTH-1:0] value);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tolerance_model = value;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic test_directed_shapes();
        // Inside and outside, each also with reversed orientation, then two points on the circle.
        send_word(make_word(0, 0, 40, 0, 0, 40, 13, 17));
        send_word(make_word(0, 0, 0, 40, 40, 0, 13, 17));
        send_word(make_word(0, 0, 40, 0, 0, 40, 60, 60));
        send_word(make_word(0, 0, 0, 40, 40, 0, 60, 60));
        send_word(make_word(0, 0, 40, 0, 0, 40, 40, 40));
        send_word(make_word(5, 5, 45, 5, 5, 45, 5, 5));
        // Collinear vertices and repeated vertices.
        send_word(make_word(-3, -3, 0, 0, 3, 3, 1, 2));
        send_word(make_word(7, -2, 7, -2, 11, 9, 0, 0));
        send_word(make_word(7, -2, 7, -2, 7, -2, 7, -2));
        // Coordinate extremes.
        send_word(make_word(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767));
        send_word(make_word(-32768, -32768, 32767, -32768, 32767, 32767, 0, 0));
        send_word(make_word(-32768, -32768, 32767, 32767, 32767, -32768, 0, 0));
        send_word(make_word(32767, 32767, -32768, 32767, -32768, -32768, 32767, -32768));
        send_word(make_word(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
        send_word(make_word(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_word(make_word(-32768, 0, 0, -32768, 32767, 32767, -32768, -32768));
    endtask

    task automatic test_tolerance_boundary();
        t_triangle_query w;
        logic signed [127:0] r;
        logic [TOL_WIDTH-1:0] mag;
        int side;
        for (side = 0; side < 2; side++) begin
            w = (side == 0) ? make_word(0, 0, 40, 0, 0, 40, 13, 17)
                            : make_word(0, 0, 0, 40, 40, 0, 13, 17);
            r = negated_det(w);
            mag = (r < 0) ? TOL_WIDTH'(-r) : TOL_WIDTH'(r);
            write_tolerance(mag);
            send_word(w);
            write_tolerance(mag - 1'b1);
            send_word(w);
        end
        write_tolerance('1);
        send_word(make_word(0, 0, 40, 0, 0, 40, 13, 17));
        send_word(make_word(-32768, -32768, 32767, -32768, 32767, 32767, 0, 0));
        send_word(make_word(-32768, 0, 0, -32768, 32767, 32767, -32768, -32768));
    endtask

    task automatic test_random_words(input int count, input logic [TOL_WIDTH-1:0] tol);
        int n;
        write_tolerance(tol);
        for (n = 0; n < count; n++) begin
            send_word(random_word());
        end
    endtask

    task automatic test_backpressure();
        int n;
        write_tolerance(TOL_WIDTH'($urandom_range(0, 4096)));
        hold_requests++;
        for (n = 0; n < 40; n++) begin
            send_word(random_word());
        end
        drain_results();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(18, 53);
        test_directed_shapes();
        test_tolerance_boundary();
        test_random_words(120, TOL_WIDTH'($urandom_range(0, 1 << 20)));

        set_idling(53, 18);
        test_random_words(120, TOL_WIDTH'({$urandom(), $urandom()}));

        set_idling(0, 0);
        test_backpressure();
        test_random_words(120, '0);

        drain_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0 && pending_relations.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/ic2d_pkg.sv
hw/rtl/ic2d_mul.sv
hw/rtl/ic2d_out.sv
hw/rtl/incircle_test_2d_unit.sv
tb/tb_top.sv
